[hdl/dimm_temp_qualifier_top_macros.svh]
// Assertion helpers shared by the RTL.
// Each check is sampled on the rising clock edge and is off while reset is low.
`ifndef DIMM_TEMP_QUALIFIER_TOP_MACROS_SVH
`define DIMM_TEMP_QUALIFIER_TOP_MACROS_SVH

// Same-cycle implication.
`define DTQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication.
`define DTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[hdl/dtq_pkg.sv]
`default_nettype none

package dtq_pkg;

    localparam int NUM_GROUPS      = 8;
    localparam int SLOTS_PER_GROUP = 8;
    localparam int NUM_SLOTS       = NUM_GROUPS * SLOTS_PER_GROUP;
    localparam int SLOT_ADDR_W     = $clog2(NUM_SLOTS);

    localparam int TEMP_W      = 8;
    localparam int FLAG_W      = 5;
    localparam int GROUP_W     = 3;
    localparam int SLOT_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int HOT_SLOT_W  = 4;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;

    localparam int FLAG_RANGE_BIT = 0;
    localparam int FLAG_FAST_BIT  = 1;

    localparam logic [TEMP_W-1:0] OVERTEMP_RESET  = TEMP_W'(85);
    localparam logic [TEMP_W-1:0] MIN_VALID_RESET = TEMP_W'(1);
    localparam logic [TEMP_W-1:0] MAX_VALID_RESET = TEMP_W'(125);
    localparam logic [TEMP_W-1:0] MAX_STEP_RESET  = TEMP_W'(2);

    typedef enum logic [STATUS_W-1:0] {
        STATUS_NEW     = 2'd0,
        STATUS_OLD     = 2'd1,
        STATUS_ERROR   = 2'd2,
        STATUS_STALLED = 2'd3
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_OVERTEMP  = 8'd0,
        CFG_MIN_VALID = 8'd1,
        CFG_MAX_VALID = 8'd2,
        CFG_MAX_STEP  = 8'd3
    } cfg_index_t;

endpackage

`default_nettype wire

[hdl/dtq_sample_if.sv]
`default_nettype none

interface dtq_sample_if;
    logic                          valid;
    logic                          ready;
    logic [dtq_pkg::GROUP_W-1:0]   group_index;
    logic [dtq_pkg::SLOT_W-1:0]    slot_index;
    logic                          sensor_enabled;
    logic [dtq_pkg::STATUS_W-1:0]  sensor_status;
    logic [dtq_pkg::TEMP_W-1:0]    reading_temp;
    logic                          scan_end;

    modport source (
        output valid, group_index, slot_index, sensor_enabled, sensor_status,
               reading_temp, scan_end,
        input  ready
    );
    modport sink (
        input  valid, group_index, slot_index, sensor_enabled, sensor_status,
               reading_temp, scan_end,
        output ready
    );
endinterface

`default_nettype wire

[hdl/dtq_result_if.sv]
`default_nettype none

interface dtq_result_if;
    logic                            valid;
    logic                            ready;
    logic [dtq_pkg::TEMP_W-1:0]      qualified_temp;
    logic [dtq_pkg::FLAG_W-1:0]      slot_flags;
    logic                            overtemp;
    logic                            temp_updated;
    logic                            recovery_request;
    logic                            scan_done;
    logic [dtq_pkg::TEMP_W-1:0]      hottest_temp;
    logic [dtq_pkg::HOT_SLOT_W-1:0]  hottest_slot;
    logic                            location_updated;

    modport source (
        output valid, qualified_temp, slot_flags, overtemp, temp_updated,
               recovery_request, scan_done, hottest_temp, hottest_slot,
               location_updated,
        input  ready
    );
    modport sink (
        input  valid, qualified_temp, slot_flags, overtemp, temp_updated,
               recovery_request, scan_done, hottest_temp, hottest_slot,
               location_updated,
        output ready
    );
endinterface

`default_nettype wire

[hdl/dtq_cfg_if.sv]
`default_nettype none

interface dtq_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [dtq_pkg::CFG_INDEX_W-1:0]    index;
    logic [dtq_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/dimm_temp_qualifier_top.sv]
// Channel   Direction  Handshake      Payload
// sample    in         valid/ready    one sensor reading for a (group, slot)
// result    out        valid/ready    qualified temperature, flags, scan summary
// cfg       in         valid/ready    register index and write data
//
// One item per cycle sustained while result is ready; each accepted item passes
// the slot store read (registered) and the qualify step into the result register.
// The slot store is one write port, one read port; a write-back register
// forwards the previous item's slot update so back-to-back items on one slot
// see fresh data. Reset clears control state and slot valid bits at once
// (no clearing pass); cfg is always ready. A stalled result holds the qualify
// stage, and sample stays ready while that stage is free.
`default_nettype none
`include "dimm_temp_qualifier_top_macros.svh"

module dimm_temp_qualifier_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    dtq_sample_if.sink         sample,
    dtq_result_if.source       result,
    dtq_cfg_if.sink            cfg
);

    localparam int TW = dtq_pkg::TEMP_W;
    localparam int FW = dtq_pkg::FLAG_W;
    localparam int AW = dtq_pkg::SLOT_ADDR_W;

    // Configuration registers
    logic [TW-1:0] overtemp_reg;
    logic [TW-1:0] min_valid_reg;
    logic [TW-1:0] max_valid_reg;
    logic [TW-1:0] max_step_reg;

    // Slot store: temperature and flags, plus a valid bit per entry
    logic [TW-1:0] temp_mem [dtq_pkg::NUM_SLOTS];
    logic [FW-1:0] flag_mem [dtq_pkg::NUM_SLOTS];
    logic [dtq_pkg::NUM_SLOTS-1:0] slot_vld_reg;

    // Qualify stage
    logic                             s1_valid_reg;
    logic [dtq_pkg::GROUP_W-1:0]      s1_group_reg;
    logic [dtq_pkg::SLOT_W-1:0]       s1_slot_reg;
    logic                             s1_enabled_reg;
    dtq_pkg::status_t                 s1_status_reg;
    logic [TW-1:0]                    s1_reading_reg;
    logic                             s1_scan_end_reg;
    logic                             s1_grp_ok_reg;
    logic                             s1_ok_reg;
    logic [AW-1:0]                    s1_addr_reg;
    logic [TW-1:0]                    rd_temp_reg;
    logic [FW-1:0]                    rd_flags_reg;
    logic                             rd_vld_reg;

    // Write-back forwarding
    logic                             byp_vld_reg;
    logic [AW-1:0]                    byp_addr_reg;
    logic [TW-1:0]                    byp_temp_reg;
    logic [FW-1:0]                    byp_flags_reg;

    // Group and scan state
    logic [dtq_pkg::NUM_GROUPS-1:0]   ran_once_reg;
    logic [TW-1:0]                    run_max_reg [dtq_pkg::NUM_GROUPS];
    logic [TW-1:0]                    scan_hot_temp_reg;
    logic [dtq_pkg::HOT_SLOT_W-1:0]   scan_hot_slot_reg;

    // Result register
    logic                             res_valid_reg;
    logic [TW-1:0]                    res_temp_reg;
    logic [FW-1:0]                    res_flags_reg;
    logic                             res_overtemp_reg;
    logic                             res_updated_reg;
    logic                             res_recovery_reg;
    logic                             res_scan_done_reg;
    logic [TW-1:0]                    res_hot_temp_reg;
    logic [dtq_pkg::HOT_SLOT_W-1:0]   res_hot_slot_reg;
    logic                             res_loc_reg;

    // Handshake
    logic          advance;
    logic          sample_acc;
    logic          in_grp_ok;
    logic          in_ok;
    logic [AW-1:0] rd_addr;

    // Qualify logic
    logic                           byp_hit;
    logic [TW-1:0]                  prev_raw;
    logic [FW-1:0]                  flags_old;
    logic [TW-1:0]                  prev;
    logic [TW:0]                    hi_sum;
    logic [TW-1:0]                  hi_lim;
    logic [TW-1:0]                  lo_lim;
    logic                           in_range;
    logic                           fast_keep;
    logic [TW-1:0]                  q_next;
    logic [FW-1:0]                  flags_next;
    logic                           overtemp_next;
    logic                           updated_next;
    logic                           recovery_next;
    logic [TW-1:0]                  cand_temp;
    logic [dtq_pkg::HOT_SLOT_W-1:0] cand_slot;
    logic                           loc_next;
    logic                           wr_en;

    // ------------------------------------------------------------------
    // Flow control: advance the qualify stage when the result register is
    // free or being emptied; take a new item whenever the stage frees up.
    // ------------------------------------------------------------------
    assign advance      = s1_valid_reg && (!res_valid_reg || result.ready);
    assign sample.ready = !s1_valid_reg || advance;
    assign sample_acc   = sample.valid && sample.ready;
    assign cfg.ready    = 1'b1;
    assign wr_en        = advance && s1_ok_reg;

    assign in_grp_ok = 32'(sample.group_index) < dtq_pkg::NUM_GROUPS;
    assign in_ok     = in_grp_ok && (32'(sample.slot_index) < dtq_pkg::SLOTS_PER_GROUP);
    assign rd_addr   = AW'(32'(sample.group_index) * dtq_pkg::SLOTS_PER_GROUP
                           + 32'(sample.slot_index));

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            overtemp_reg  <= dtq_pkg::OVERTEMP_RESET;
            min_valid_reg <= dtq_pkg::MIN_VALID_RESET;
            max_valid_reg <= dtq_pkg::MAX_VALID_RESET;
            max_step_reg  <= dtq_pkg::MAX_STEP_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                dtq_pkg::CFG_OVERTEMP:  overtemp_reg  <= cfg.data;
                dtq_pkg::CFG_MIN_VALID: min_valid_reg <= cfg.data;
                dtq_pkg::CFG_MAX_VALID: max_valid_reg <= cfg.data;
                dtq_pkg::CFG_MAX_STEP:  max_step_reg  <= cfg.data;
                default:                ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Slot store: read on accept, write back as the item leaves the
    // qualify stage. Read data is registered.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (sample_acc)
        begin
            rd_temp_reg  <= temp_mem[rd_addr];
            rd_flags_reg <= flag_mem[rd_addr];
        end
        if (wr_en)
        begin
            temp_mem[s1_addr_reg] <= q_next;
            flag_mem[s1_addr_reg] <= flags_next;
        end
    end

    // ------------------------------------------------------------------
    // Qualify stage payload (no reset needed)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (sample_acc)
        begin
            s1_group_reg    <= sample.group_index;
            s1_slot_reg     <= sample.slot_index;
            s1_enabled_reg  <= sample.sensor_enabled;
            s1_status_reg   <= dtq_pkg::status_t'(sample.sensor_status);
            s1_reading_reg  <= sample.reading_temp;
            s1_scan_end_reg <= sample.scan_end;
            s1_grp_ok_reg   <= in_grp_ok;
            s1_ok_reg       <= in_ok;
            s1_addr_reg     <= rd_addr;
        end
        if (wr_en)
        begin
            byp_addr_reg  <= s1_addr_reg;
            byp_temp_reg  <= q_next;
            byp_flags_reg <= flags_next;
        end
        if (advance)
        begin
            res_temp_reg      <= q_next;
            res_flags_reg     <= flags_next;
            res_overtemp_reg  <= overtemp_next;
            res_updated_reg   <= updated_next;
            res_recovery_reg  <= recovery_next;
            res_scan_done_reg <= s1_scan_end_reg;
            res_hot_temp_reg  <= s1_scan_end_reg ? cand_temp : '0;
            res_hot_slot_reg  <= s1_scan_end_reg ? cand_slot : '0;
            res_loc_reg       <= loc_next;
        end
    end

    // ------------------------------------------------------------------
    // Control state: valids, slot valid bits, group and scan state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            res_valid_reg     <= 1'b0;
            rd_vld_reg        <= 1'b0;
            byp_vld_reg       <= 1'b0;
            slot_vld_reg      <= '0;
            ran_once_reg      <= '0;
            run_max_reg       <= '{default: '0};
            scan_hot_temp_reg <= '0;
            scan_hot_slot_reg <= dtq_pkg::HOT_SLOT_W'(dtq_pkg::SLOTS_PER_GROUP);
        end
        else
        begin
            if (sample_acc)
            begin
                s1_valid_reg <= 1'b1;
                rd_vld_reg   <= slot_vld_reg[rd_addr];
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end

            if (wr_en)
            begin
                byp_vld_reg               <= 1'b1;
                slot_vld_reg[s1_addr_reg] <= 1'b1;
            end

            if (advance)
            begin
                if (s1_scan_end_reg)
                begin
                    // Close the scan: fold into the group maximum, restart search
                    if (s1_grp_ok_reg)
                    begin
                        ran_once_reg[s1_group_reg] <= 1'b1;
                        if (loc_next)
                        begin
                            run_max_reg[s1_group_reg] <= cand_temp;
                        end
                    end
                    scan_hot_temp_reg <= '0;
                    scan_hot_slot_reg <= dtq_pkg::HOT_SLOT_W'(dtq_pkg::SLOTS_PER_GROUP);
                end
                else
                begin
                    scan_hot_temp_reg <= cand_temp;
                    scan_hot_slot_reg <= cand_slot;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Qualify one reading
    // ------------------------------------------------------------------
    assign byp_hit = byp_vld_reg && (byp_addr_reg == s1_addr_reg);

    always_comb
    begin
        // Stored slot state; never-written entries read as zero
        if (byp_hit)
        begin
            prev_raw  = byp_temp_reg;
            flags_old = byp_flags_reg;
        end
        else if (rd_vld_reg)
        begin
            prev_raw  = rd_temp_reg;
            flags_old = rd_flags_reg;
        end
        else
        begin
            prev_raw  = '0;
            flags_old = '0;
        end

        // Zero means no stored value: the current reading stands in
        prev = (prev_raw == '0) ? s1_reading_reg : prev_raw;

        hi_sum    = {1'b0, prev} + {1'b0, max_step_reg};
        hi_lim    = hi_sum[TW] ? {TW{1'b1}} : hi_sum[TW-1:0];
        lo_lim    = prev - max_step_reg;
        in_range  = (s1_reading_reg >= min_valid_reg) && (s1_reading_reg <= max_valid_reg);
        fast_keep = (flags_old == '0) || flags_old[dtq_pkg::FLAG_FAST_BIT];

        q_next        = '0;
        flags_next    = '0;
        overtemp_next = 1'b0;
        updated_next  = 1'b0;
        recovery_next = 1'b0;

        if (s1_ok_reg)
        begin
            flags_next = flags_old;
            if (s1_enabled_reg)
            begin
                if (s1_status_reg == dtq_pkg::STATUS_NEW)
                begin
                    if (!in_range)
                    begin
                        flags_next[dtq_pkg::FLAG_RANGE_BIT] = 1'b1;
                        q_next = prev;
                    end
                    else
                    begin
                        // Slew limit; any accepted reading clears all but fast change
                        flags_next   = '0;
                        updated_next = 1'b1;
                        if (s1_reading_reg > hi_lim)
                        begin
                            q_next = hi_lim;
                            flags_next[dtq_pkg::FLAG_FAST_BIT] = fast_keep;
                        end
                        else if ((prev >= max_step_reg) && (s1_reading_reg < lo_lim))
                        begin
                            q_next = lo_lim;
                            flags_next[dtq_pkg::FLAG_FAST_BIT] = fast_keep;
                        end
                        else
                        begin
                            q_next = s1_reading_reg;
                        end
                    end
                end
                else
                begin
                    // Status flags only count after the group's first scan
                    if (ran_once_reg[s1_group_reg])
                    begin
                        flags_next[3'(s1_status_reg) + 3'd1] = 1'b1;
                    end
                    q_next        = prev;
                    recovery_next = (s1_status_reg == dtq_pkg::STATUS_ERROR);
                end
                overtemp_next = (q_next >= overtemp_reg);
            end
        end

        // Hottest of the scan, earliest slot wins ties
        if (s1_ok_reg && (q_next > scan_hot_temp_reg))
        begin
            cand_temp = q_next;
            cand_slot = dtq_pkg::HOT_SLOT_W'(s1_slot_reg);
        end
        else
        begin
            cand_temp = scan_hot_temp_reg;
            cand_slot = scan_hot_slot_reg;
        end

        loc_next = s1_scan_end_reg && s1_grp_ok_reg
                   && (cand_temp > run_max_reg[s1_group_reg]);
    end

    // ------------------------------------------------------------------
    // Result port
    // ------------------------------------------------------------------
    assign result.valid            = res_valid_reg;
    assign result.qualified_temp   = res_temp_reg;
    assign result.slot_flags       = res_flags_reg;
    assign result.overtemp         = res_overtemp_reg;
    assign result.temp_updated     = res_updated_reg;
    assign result.recovery_request = res_recovery_reg;
    assign result.scan_done        = res_scan_done_reg;
    assign result.hottest_temp     = res_hot_temp_reg;
    assign result.hottest_slot     = res_hot_slot_reg;
    assign result.location_updated = res_loc_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `DTQ_ASSERT_NOW(a_overtemp_consistent, clk, rst_n,
        res_valid_reg && res_overtemp_reg, res_temp_reg >= overtemp_reg)
    `DTQ_ASSERT_NOW(a_summary_only_on_scan_end, clk, rst_n,
        res_valid_reg && !res_scan_done_reg,
        (res_hot_temp_reg == '0) && (res_hot_slot_reg == '0) && !res_loc_reg)
    `DTQ_ASSERT_NOW(a_location_needs_heat, clk, rst_n,
        res_valid_reg && res_loc_reg, res_scan_done_reg && (res_hot_temp_reg != '0))
    `DTQ_ASSERT_NOW(a_update_excludes_recovery, clk, rst_n,
        res_valid_reg && res_updated_reg, !res_recovery_reg && !res_flags_reg[0])
    `DTQ_ASSERT_NEXT(a_scan_restarts, clk, rst_n,
        advance && s1_scan_end_reg,
        (scan_hot_temp_reg == '0)
        && (scan_hot_slot_reg == dtq_pkg::HOT_SLOT_W'(dtq_pkg::SLOTS_PER_GROUP)))

endmodule

`default_nettype wire

[sim/dtq_checker.sv]
`timescale 1ns / 1ps

module dtq_checker
    import dtq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    dtq_sample_if sample,
    dtq_result_if result,
    dtq_cfg_if    cfg,
    output int    mismatches,
    output int    outstanding
);

    localparam int TEMP_CEIL = (1 << TEMP_W) - 1;

    typedef struct packed {
        logic [TEMP_W-1:0]     qualified_temp;
        logic [FLAG_W-1:0]     slot_flags;
        logic                  overtemp;
        logic                  temp_updated;
        logic                  recovery_request;
        logic                  scan_done;
        logic [TEMP_W-1:0]     hottest_temp;
        logic [HOT_SLOT_W-1:0] hottest_slot;
        logic                  location_updated;
    } qual_result_t;

    logic [TEMP_W-1:0]     overtemp_threshold;
    logic [TEMP_W-1:0]     min_valid;
    logic [TEMP_W-1:0]     max_valid;
    logic [TEMP_W-1:0]     max_step;

    logic [TEMP_W-1:0]     stored_temp  [NUM_SLOTS];
    logic [FLAG_W-1:0]     stored_flags [NUM_SLOTS];
    logic                  ran_once     [NUM_GROUPS];
    logic [TEMP_W-1:0]     group_peak   [NUM_GROUPS];
    logic [TEMP_W-1:0]     scan_peak_temp;
    logic [HOT_SLOT_W-1:0] scan_peak_slot;

    qual_result_t          qualified_q[$];
    int                    fail_total;

    assign mismatches = fail_total;

    // Qualify one reading against the slot store and return the result it yields.
    function automatic qual_result_t qualify_reading(
        input logic [GROUP_W-1:0] grp,
        input logic [SLOT_W-1:0]  slot,
        input logic               enabled,
        input status_t            status,
        input logic [TEMP_W-1:0]  reading,
        input logic               last
    );
        qual_result_t           r;
        logic [SLOT_ADDR_W-1:0] idx;
        int                     upper;
        logic [TEMP_W-1:0]      prev;
        logic [FLAG_W-1:0]      flags;
        r = '0;
        if (int'(grp) < NUM_GROUPS && int'(slot) < SLOTS_PER_GROUP)
        begin
            idx   = SLOT_ADDR_W'(int'(grp) * SLOTS_PER_GROUP + int'(slot));
            flags = stored_flags[idx];
            if (enabled)
            begin
                prev = (stored_temp[idx] == '0) ? reading : stored_temp[idx];
                if (status == STATUS_NEW)
                begin
                    if (reading < min_valid || reading > max_valid)
                    begin
                        flags[FLAG_RANGE_BIT] = 1'b1;
                        r.qualified_temp = prev;
                    end
                    else
                    begin
                        upper = int'(prev) + int'(max_step);
                        if (upper > TEMP_CEIL)
                            upper = TEMP_CEIL;
                        if (int'(reading) > upper)
                        begin
                            r.qualified_temp = TEMP_W'(upper);
                            if (flags == '0)
                                flags[FLAG_FAST_BIT] = 1'b1;
                        end
                        else if (prev >= max_step && reading < prev - max_step)
                        begin
                            r.qualified_temp = prev - max_step;
                            if (flags == '0)
                                flags[FLAG_FAST_BIT] = 1'b1;
                        end
                        else
                        begin
                            r.qualified_temp = reading;
                            flags[FLAG_FAST_BIT] = 1'b0;
                        end
                        r.temp_updated = 1'b1;
                        flags = flags & (FLAG_W'(1) << FLAG_FAST_BIT);
                    end
                end
                else
                begin
                    if (ran_once[grp])
                        flags[3'(status) + 3'd1] = 1'b1;
                    r.qualified_temp   = prev;
                    r.recovery_request = (status == STATUS_ERROR);
                end
                r.overtemp = (r.qualified_temp >= overtemp_threshold);
            end
            stored_temp[idx]  = r.qualified_temp;
            stored_flags[idx] = flags;
            r.slot_flags      = flags;
            if (r.qualified_temp > scan_peak_temp)
            begin
                scan_peak_temp = r.qualified_temp;
                scan_peak_slot = HOT_SLOT_W'(slot);
            end
        end
        if (last)
        begin
            r.scan_done    = 1'b1;
            r.hottest_temp = scan_peak_temp;
            r.hottest_slot = scan_peak_slot;
            if (int'(grp) < NUM_GROUPS)
            begin
                if (scan_peak_temp > group_peak[grp])
                begin
                    r.location_updated = 1'b1;
                    group_peak[grp]    = scan_peak_temp;
                end
                ran_once[grp] = 1'b1;
            end
            scan_peak_temp = '0;
            scan_peak_slot = HOT_SLOT_W'(SLOTS_PER_GROUP);
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        qual_result_t want;
        if (!rst_n)
        begin
            overtemp_threshold = OVERTEMP_RESET;
            min_valid          = MIN_VALID_RESET;
            max_valid          = MAX_VALID_RESET;
            max_step           = MAX_STEP_RESET;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                stored_temp[i]  = '0;
                stored_flags[i] = '0;
            end
            for (int i = 0; i < NUM_GROUPS; i++)
            begin
                ran_once[i]   = 1'b0;
                group_peak[i] = '0;
            end
            scan_peak_temp = '0;
            scan_peak_slot = HOT_SLOT_W'(SLOTS_PER_GROUP);
            qualified_q.delete();
            fail_total = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg_index_t'(cfg.index))
                    CFG_OVERTEMP:  overtemp_threshold = cfg.data;
                    CFG_MIN_VALID: min_valid          = cfg.data;
                    CFG_MAX_VALID: max_valid          = cfg.data;
                    CFG_MAX_STEP:  max_step           = cfg.data;
                    default: ;
                endcase
            end
            // Retire the oldest expectation before queuing this edge's item.
            if (result.valid && result.ready)
            begin
                if (qualified_q.size() == 0)
                begin
                    $error("result item with no expectation pending");
                    fail_total++;
                end
                else
                begin
                    want = qualified_q.pop_front();
                    check_field("qualified_temp", want.qualified_temp,
                                result.qualified_temp);
                    check_field("slot_flags", want.slot_flags, result.slot_flags);
                    check_field("overtemp", want.overtemp, result.overtemp);
                    check_field("temp_updated", want.temp_updated, result.temp_updated);
                    check_field("recovery_request", want.recovery_request,
                                result.recovery_request);
                    check_field("scan_done", want.scan_done, result.scan_done);
                    check_field("hottest_temp", want.hottest_temp, result.hottest_temp);
                    check_field("hottest_slot", want.hottest_slot, result.hottest_slot);
                    check_field("location_updated", want.location_updated,
                                result.location_updated);
                end
            end
            if (sample.valid && sample.ready)
                qualified_q.push_back(qualify_reading(sample.group_index, sample.slot_index,
                    sample.sensor_enabled, status_t'(sample.sensor_status),
                    sample.reading_temp, sample.scan_end));
            outstanding <= qualified_q.size();
        end
    end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import dtq_pkg::*;

    logic clk;
    logic rst_n;

    dtq_sample_if sample_ch ();
    dtq_result_if result_ch ();
    dtq_cfg_if    cfg_ch ();

    int mismatches;
    int outstanding;

    // Percent of cycles the sender idles before an item / the receiver holds ready low.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Plausible range currently programmed; steer well-formed scans into it.
    logic [TEMP_W-1:0] lo_temp = MIN_VALID_RESET;
    logic [TEMP_W-1:0] hi_temp = MAX_VALID_RESET;

    // Per-group nominal temperature that drifts slowly from scan to scan.
    int group_base [NUM_GROUPS];

    dimm_temp_qualifier_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    dtq_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample_ch),
        .result      (result_ch),
        .cfg         (cfg_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs on a handshake.
    initial
    begin
        #3_000_000;
        $display("[dimm_temp_qualifier_top] ERROR");
        $finish;
    end

    // Result side: drop ready at random according to the current stall rate.
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic int clamp_temp(input int value, input int floor_v, input int ceil_v);
        if (value < floor_v)
            return floor_v;
        if (value > ceil_v)
            return ceil_v;
        return value;
    endfunction

    // Offer one reading; idle first at the sender's rate, then hold until taken.
    // Valid stays high on return so back-to-back items need no extra edge.
    task automatic send_reading(input int grp, input int slot, input bit enabled,
                                input status_t status, input int temp, input bit last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid          <= 1'b1;
        sample_ch.group_index    <= GROUP_W'(grp);
        sample_ch.slot_index     <= SLOT_W'(slot);
        sample_ch.sensor_enabled <= enabled;
        sample_ch.sensor_status  <= status;
        sample_ch.reading_temp   <= TEMP_W'(temp);
        sample_ch.scan_end       <= last;
        do
            @(posedge clk);
        while (!sample_ch.ready);
    endtask

    // Stop offering and wait until every queued item has produced its result.
    task automatic drain();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Program all four registers back to back; the block must be idle here.
    task automatic load_settings(input logic [TEMP_W-1:0] threshold,
                                 input logic [TEMP_W-1:0] lo,
                                 input logic [TEMP_W-1:0] hi,
                                 input logic [TEMP_W-1:0] step);
        cfg_index_t             which [4] = '{CFG_OVERTEMP, CFG_MIN_VALID,
                                              CFG_MAX_VALID, CFG_MAX_STEP};
        logic [CFG_DATA_W-1:0]  value [4];
        value = '{threshold, lo, hi, step};
        for (int i = 0; i < 4; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= which[i];
            cfg_ch.data  <= value[i];
            do
                @(posedge clk);
            while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
        lo_temp = lo;
        hi_temp = hi;
    endtask

    // Mostly well-formed scans over a run of slots of one group, with readings
    // jittering around a drifting nominal; the rest are fully random items.
    task automatic run_phase(input int item_goal);
        int      sent;
        int      nslots;
        int      first;
        int      grp;
        int      temp;
        status_t status;
        sent = 0;
        while (sent < item_goal)
        begin
            if ($urandom_range(99) < 80)
            begin
                grp = $urandom_range(NUM_GROUPS - 1);
                if (lo_temp > hi_temp)
                    group_base[grp] = $urandom_range(255);
                else if ($urandom_range(9) == 0)
                    group_base[grp] = $urandom_range(hi_temp, lo_temp);
                else
                    group_base[grp] = clamp_temp(group_base[grp] + int'($urandom_range(6)) - 3,
                                                 int'(lo_temp), int'(hi_temp));
                nslots = $urandom_range(SLOTS_PER_GROUP, 1);
                first  = $urandom_range(SLOTS_PER_GROUP - nslots);
                for (int k = 0; k < nslots; k++)
                begin
                    temp   = clamp_temp(group_base[grp] + int'($urandom_range(8)) - 4, 0, 255);
                    status = ($urandom_range(99) < 85) ? STATUS_NEW
                                                        : status_t'($urandom_range(3));
                    send_reading(grp, first + k, $urandom_range(9) != 0, status, temp,
                                 k == nslots - 1);
                    sent++;
                end
            end
            else
            begin
                send_reading($urandom_range(NUM_GROUPS - 1),
                             $urandom_range(SLOTS_PER_GROUP - 1),
                             1'($urandom_range(1)), status_t'($urandom_range(3)),
                             $urandom_range(255), $urandom_range(4) == 0);
                sent++;
            end
        end
    endtask

    initial
    begin
        // Hold every input at a known value while reset is asserted.
        rst_n = 1'b0;
        sample_ch.valid          <= 1'b0;
        sample_ch.group_index    <= '0;
        sample_ch.slot_index     <= '0;
        sample_ch.sensor_enabled <= 1'b0;
        sample_ch.sensor_status  <= STATUS_NEW;
        sample_ch.reading_temp   <= '0;
        sample_ch.scan_end       <= 1'b0;
        cfg_ch.valid             <= 1'b0;
        cfg_ch.index             <= CFG_OVERTEMP;
        cfg_ch.data              <= '0;
        for (int i = 0; i < NUM_GROUPS; i++)
            group_base[i] = 60;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pass at reset settings (threshold 85, range 1..125, step 2).
        // First reading on an empty slot stands in for the stored value.
        send_reading(0, 0, 1'b1, STATUS_NEW, 50, 1'b0);
        // Clip upward, then downward, by the step limit.
        send_reading(0, 0, 1'b1, STATUS_NEW, 60, 1'b0);
        send_reading(0, 0, 1'b1, STATUS_NEW, 40, 1'b0);
        // Readings at both ends of the field are implausible.
        send_reading(0, 0, 1'b1, STATUS_NEW, 0, 1'b0);
        send_reading(0, 0, 1'b1, STATUS_NEW, 255, 1'b0);
        // Non-new statuses before the group has finished a scan: no status flags.
        send_reading(0, 0, 1'b1, STATUS_OLD, 70, 1'b0);
        send_reading(0, 1, 1'b1, STATUS_ERROR, 30, 1'b0);
        send_reading(0, 2, 1'b1, STATUS_STALLED, 0, 1'b0);
        // Disabled slot stores zero.
        send_reading(0, 3, 1'b0, STATUS_NEW, 255, 1'b0);
        // Close the scan at the top of the valid range; running max moves.
        send_reading(0, 7, 1'b1, STATUS_NEW, 125, 1'b1);
        // Group has run once now: status flags get recorded.
        send_reading(0, 0, 1'b1, STATUS_OLD, 50, 1'b0);
        send_reading(0, 0, 1'b1, STATUS_ERROR, 50, 1'b0);
        send_reading(0, 0, 1'b1, STATUS_STALLED, 50, 1'b0);
        // Accepted in-range reading clears the flags; scan below running max.
        send_reading(0, 0, 1'b1, STATUS_NEW, 51, 1'b1);
        // Bottom of the range, and just above the top on an empty slot.
        send_reading(7, 7, 1'b1, STATUS_NEW, 1, 1'b0);
        send_reading(7, 6, 1'b1, STATUS_NEW, 126, 1'b1);
        // Tie for hottest: earliest slot wins; over threshold.
        send_reading(5, 2, 1'b1, STATUS_NEW, 90, 1'b0);
        send_reading(5, 3, 1'b1, STATUS_NEW, 90, 1'b0);
        send_reading(5, 4, 1'b0, STATUS_NEW, 90, 1'b1);
        // Scan with nothing but zeros reports no hottest slot.
        send_reading(6, 0, 1'b0, STATUS_ERROR, 200, 1'b1);
        // Cooler rescan of group five: location stays put.
        send_reading(5, 2, 1'b1, STATUS_NEW, 84, 1'b1);
        // Exactly at the threshold.
        send_reading(1, 5, 1'b1, STATUS_NEW, 85, 1'b1);
        drain();

        // Random phases: cycle through idle patterns and register settings,
        // draining before each reprogram so the block is quiet.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                1: load_settings(8'd0, 8'd0, 8'd255, 8'd0);
                2: load_settings(8'd255, 8'd255, 8'd255, 8'd255);
                3: load_settings(8'd60, 8'd20, 8'd90, 8'd5);
                4: load_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                                 8'($urandom_range(255)), 8'($urandom_range(255)));
                5: load_settings(8'd128, 8'd1, 8'd254, 8'd1);
                default: ;
            endcase
            case (phase % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 73;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 73;
                end
                default:
                begin
                    send_idle_pct  = 6;
                    recv_stall_pct = 6;
                end
            endcase
            run_phase(250);
            drain();
        end

        repeat (10) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("[dimm_temp_qualifier_top] OK");
        else
            $display("[dimm_temp_qualifier_top] ERROR");
        $finish;
    end

endmodule
